// ----- src/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants of the boundary pixel extractor
// Frame limits, field widths, register indexes and the line control bundle.
// ----------------------------------------------------------------------------
package bpe_pkg;

	// frame limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// internal coordinate widths
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// fixed field widths of the ports
	localparam int PIX_W       = 8;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int COL_FIELD_W = 10;
	localparam int ROW_FIELD_W = 10;
	localparam int SEQ_W       = 20;
	localparam int OUT_W       = COL_FIELD_W + ROW_FIELD_W + SEQ_W;

	// per-column line entry: bit0 latest row, bit1 row before
	localparam int ENTRY_W = 2;

	// background values by polarity
	localparam logic [PIX_W-1:0] BG_DARK  = 8'd0;
	localparam logic [PIX_W-1:0] BG_LIGHT = 8'd255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_POLARITY = 2'd2
	} cfg_reg_t;

	// control bundle from the sequencer to the line of cells
	typedef struct packed {
		logic               shift;
		logic [COL_W-1:0]   last_col;
		logic [ENTRY_W-1:0] wr_entry;
	} line_ctrl_t;

endpackage

// ----- src/bpe_cell.sv -----
// ----------------------------------------------------------------------------
// bpe_cell: one column slot of the line store
// Holds one two-bit entry; takes its neighbor's entry on a shift, or the new
// entry when it is the insertion slot of the current width.
// ----------------------------------------------------------------------------
module bpe_cell (
	input  logic                         clk,
	input  logic                         shift,
	input  logic                         load,
	input  logic [bpe_pkg::ENTRY_W-1:0]  next_entry,
	input  logic [bpe_pkg::ENTRY_W-1:0]  new_entry,
	output logic [bpe_pkg::ENTRY_W-1:0]  entry
);
	import bpe_pkg::*;

	logic [ENTRY_W-1:0] entry_q;

	// slot register, payload only
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= load ? new_entry : next_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ----- src/bpe_line.sv -----
// ----------------------------------------------------------------------------
// bpe_line: circular line store built as a chain of cells
// Slot 0 holds the entry of the current column, slot 1 the next one. Each
// transfer moves the chain one slot toward slot 0 and inserts the new entry at
// the slot given by the active width, so the line rotates once per row.
// ----------------------------------------------------------------------------
module bpe_line (
	input  logic                         clk,
	input  bpe_pkg::line_ctrl_t          ctrl,
	output logic [bpe_pkg::ENTRY_W-1:0]  cur_entry,
	output logic [bpe_pkg::ENTRY_W-1:0]  next_entry
);
	import bpe_pkg::*;

	logic [ENTRY_W-1:0] slot [MAX_WIDTH];
	logic [ENTRY_W-1:0] feed [MAX_WIDTH];
	logic               ins  [MAX_WIDTH];

	// chain of cells, each fed by its upper neighbor
	for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
		assign feed[i] = (i == MAX_WIDTH - 1) ? '0 : slot[(i + 1) % MAX_WIDTH];
		assign ins[i]  = (ctrl.last_col == COL_W'(i));

		bpe_cell u_cell (
			.clk        (clk),
			.shift      (ctrl.shift),
			.load       (ins[i]),
			.next_entry (feed[i]),
			.new_entry  (ctrl.wr_entry),
			.entry      (slot[i])
		);
	end

	// fixed read taps
	assign cur_entry  = slot[0];
	assign next_entry = slot[1];

endmodule

// ----- src/boundary_pixel_extract_top.sv -----
// ----------------------------------------------------------------------------
// boundary_pixel_extract_top: 4-connected boundary pixel extractor
// Streams an 8-bit image in raster order and emits the boundary pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: tuser is the command (0 pixel,
//   1 drain tick), tdata the grey value. A frame is image_width x image_height
//   pixels, followed by image_width drain ticks that settle the last row.
//   m_axis carries one boundary pixel per transfer (column, row, running index).
//   cfg writes a register by index (0 width, 1 height, 2 polarity) and
//   restarts the frame; write only while the block is idle. cfg_ready is high.
// Timing:
//   one item per cycle while s_axis_tready is high; a result is visible in
//   the cycle after its item's transfer. The line store is a chain of one
//   cell per column that moves one slot per item.
//   Decisions lag by one line: a pixel of row r settles the pixel above it.
// Reset and stall:
//   reset restores width 1024, height 1024, dark background and frame start;
//   line store contents stay unknown until the first row is written.
//   The output register holds a result while m_axis_tready is low; s_axis
//   still takes items while that register is free or being drained.
// ----------------------------------------------------------------------------
module boundary_pixel_extract_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bpe_pkg::PIX_W-1:0]         s_axis_tdata,  // [7:0] pixel
	input  logic                              s_axis_tuser,  // [0] command
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bpe_pkg::OUT_W-1:0]         m_axis_tdata,  // [9:0] col, [19:10] row,
	                                                         // [39:20] seq_index
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpe_pkg::CFG_W-1:0]         cfg_data
);
	import bpe_pkg::*;

	// configuration
	logic [COL_W-1:0]   last_col_q;
	logic [ROW_W-1:0]   last_row_q;
	logic               white_on_black_q;

	// frame position and counters
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               draining_q;
	logic               left_q;
	logic [SEQ_W-1:0]   found_q;

	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	// combinational step
	logic               cfg_fire;
	logic               in_fire;
	logic               do_drain;
	logic               do_pixel;
	logic               fg;
	logic               at_last_col;
	logic               at_last_row;
	logic               hit;
	logic               emit;
	logic [ROW_W-1:0]   out_row;
	logic [ENTRY_W-1:0] cur_entry;
	logic [ENTRY_W-1:0] next_entry;
	logic [PIX_W-1:0]   bg;
	line_ctrl_t         line_ctrl;

	// handshakes
	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid & cfg_ready;
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign do_drain      = in_fire & s_axis_tuser & draining_q;
	assign do_pixel      = in_fire & ~s_axis_tuser & ~draining_q;

	// boundary decision for the pixel above the current one, or for the last row on a drain tick
	always_comb begin
		bg          = white_on_black_q ? BG_DARK : BG_LIGHT;
		fg          = (s_axis_tdata != bg);
		at_last_col = (col_q == last_col_q);
		at_last_row = (row_q == last_row_q);
		if (do_drain) begin
			hit     = cur_entry[0];
			out_row = row_q;
		end else begin
			hit = (row_q != '0) & cur_entry[0]
			    & ((row_q == ROW_W'(1)) | (col_q == '0) | at_last_col
			       | ~left_q | ~next_entry[0] | ~cur_entry[1] | ~fg);
			out_row = row_q - ROW_W'(1);
		end
		emit = (do_drain | do_pixel) & hit;
	end

	// line store control: rotate on drain, insert new entry on pixel
	always_comb begin
		line_ctrl.shift    = do_drain | do_pixel;
		line_ctrl.last_col = last_col_q;
		line_ctrl.wr_entry = do_drain ? cur_entry : {cur_entry[0], fg};
	end

	bpe_line u_line (
		.clk        (clk),
		.ctrl       (line_ctrl),
		.cur_entry  (cur_entry),
		.next_entry (next_entry)
	);

	// configuration registers, clamped to the supported frame size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q       <= COL_W'(MAX_WIDTH - 1);
			last_row_q       <= ROW_W'(MAX_HEIGHT - 1);
			white_on_black_q <= 1'b1;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_WIDTH: begin
					if (cfg_data == '0)
						last_col_q <= '0;
					else if (int'(cfg_data) > MAX_WIDTH)
						last_col_q <= COL_W'(MAX_WIDTH - 1);
					else
						last_col_q <= COL_W'(cfg_data - CFG_W'(1));
				end
				REG_HEIGHT: begin
					if (cfg_data == '0)
						last_row_q <= '0;
					else if (int'(cfg_data) > MAX_HEIGHT)
						last_row_q <= ROW_W'(MAX_HEIGHT - 1);
					else
						last_row_q <= ROW_W'(cfg_data - CFG_W'(1));
				end
				REG_POLARITY: white_on_black_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			draining_q <= 1'b0;
			left_q     <= 1'b0;
			found_q    <= '0;
		end else if (cfg_fire) begin
			if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
			    || cfg_index == REG_POLARITY) begin
				col_q      <= '0;
				row_q      <= '0;
				draining_q <= 1'b0;
				left_q     <= 1'b0;
				found_q    <= '0;
			end
		end else if (do_drain) begin
			if (at_last_col) begin
				col_q      <= '0;
				row_q      <= '0;
				draining_q <= 1'b0;
				left_q     <= 1'b0;
				found_q    <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
				if (emit)
					found_q <= found_q + SEQ_W'(1);
			end
		end else if (do_pixel) begin
			if (emit)
				found_q <= found_q + SEQ_W'(1);
			if (at_last_col) begin
				col_q  <= '0;
				left_q <= 1'b0;
				if (at_last_row)
					draining_q <= 1'b1;
				else
					row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
				if (row_q != '0)
					left_q <= cur_entry[0];
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {found_q, ROW_FIELD_W'(out_row), COL_FIELD_W'(col_q)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- test/boundary_pixel_extract_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_pixel_extract_top_test: self-checking bench of the boundary extractor
// Streams frames of random grey pixels, drain ticks and stray items under
// random idling on both streams, and compares every boundary pixel with a
// cycle-free line-buffer predictor kept alongside the block.
// ----------------------------------------------------------------------------
module boundary_pixel_extract_top_test;
	import bpe_pkg::*;

	// item commands carried in tuser
	localparam bit CMD_PIXEL = 1'b0;
	localparam bit CMD_DRAIN = 1'b1;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 240;
	localparam int QUIET_TAIL    = 60;

	// one boundary pixel as it leaves the block
	typedef struct packed {
		logic [COL_FIELD_W-1:0] col;
		logic [ROW_FIELD_W-1:0] row;
		logic [SEQ_W-1:0]       seq;
	} boundary_hit_t;

	// one row of the directed table: a register write or a stream item
	typedef struct {
		bit                is_reg;
		cfg_reg_t          sel;
		logic [CFG_W-1:0]  value;
		bit                cmd;
		logic [PIX_W-1:0]  pix;
		bit                typed;
		bit                has_res;
		boundary_hit_t     res;
	} stim_row_t;

	localparam int N_DIRECTED = 29;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [PIX_W-1:0]     s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_W-1:0]     m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;

	// predictor state
	int       cfg_width = 1024;
	int       cfg_height = 1024;
	bit       dark_bg = 1'b1;
	bit [1:0] line_fg [MAX_WIDTH];
	bit       left_fg;
	int       col_pos;
	int       row_pos;
	bit       draining;
	bit [SEQ_W-1:0] found;

	boundary_hit_t pending_hits [$];

	int  item_count;
	int  hit_count;
	int  reg_writes;
	int  error_count;
	int  src_gap_pct;
	int  snk_stall_pct;
	int  stall_left;
	bit  mid_frame;

	// directed table: degenerate sizes, stray items, then a full 3x3 frame
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{1'b1, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b1, REG_HEIGHT,   11'd0, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b1, REG_POLARITY, 11'd1, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hFF, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h00, 1'b1, 1'b1, '{10'd0, 10'd0, 20'd0}},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'hA5, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h00, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h5A, 1'b1, 1'b0, '0},
		'{1'b1, REG_WIDTH,    11'd2, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h80, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h7F, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hFF, 1'b1, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'hFF, 1'b1, 1'b1, '{10'd0, 10'd0, 20'd0}},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h00, 1'b1, 1'b1, '{10'd1, 10'd0, 20'd1}},
		'{1'b1, REG_POLARITY, 11'd0, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b1, REG_WIDTH,    11'd3, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b1, REG_HEIGHT,   11'd3, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h01, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hFE, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h55, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hAA, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h0F, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hF0, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'h33, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_PIXEL, 8'hCC, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, REG_WIDTH,    11'd0, CMD_DRAIN, 8'h00, 1'b0, 1'b0, '0}
	};

	boundary_pixel_extract_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int clamp_dim(input int v, input int maxv);
		if (v < 1)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	function automatic void restart_frame();
		left_fg  = 1'b0;
		col_pos  = 0;
		row_pos  = 0;
		draining = 1'b0;
		found    = '0;
	endfunction

	function automatic boundary_hit_t make_hit(input int x, input int y);
		boundary_hit_t h;
		h.col = COL_FIELD_W'(x);
		h.row = ROW_FIELD_W'(y);
		h.seq = found;
		found = found + 1'b1;
		return h;
	endfunction

	// line-buffer predictor: one item in, at most one boundary pixel out
	function automatic void predict_boundary(input bit cmd, input logic [PIX_W-1:0] pix,
		output bit got, output boundary_hit_t hit);
		int w;
		int h;
		int x;
		int r;
		bit fg;
		bit center;
		bit on_rim;
		bit hit_now;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		got = 1'b0;
		hit = '0;
		x = (col_pos >= w) ? w - 1 : col_pos;
		// drain ticks settle the last row, which lies on the rim
		if (cmd == CMD_DRAIN) begin
			if (!draining)
				return;
			if (line_fg[x][0]) begin
				hit = make_hit(x, row_pos);
				got = 1'b1;
			end
			col_pos = x + 1;
			if (col_pos >= w)
				restart_frame();
			return;
		end
		if (draining)
			return;
		fg = (pix != (dark_bg ? BG_DARK : BG_LIGHT));
		r = row_pos;
		center = line_fg[x][0];
		// this pixel decides the one above it
		if (r >= 1) begin
			if (center) begin
				on_rim = (r - 1 == 0) || (x == 0) || (x + 1 >= w) || (r >= h);
				hit_now = on_rim;
				if (!on_rim && (!left_fg || !line_fg[x + 1][0] || !line_fg[x][1] || !fg))
					hit_now = 1'b1;
				if (hit_now) begin
					hit = make_hit(x, r - 1);
					got = 1'b1;
				end
			end
			left_fg = center;
		end
		line_fg[x] = {center, fg};
		col_pos = x + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			left_fg = 1'b0;
			if (r + 1 >= h)
				draining = 1'b1;
			else
				row_pos = r + 1;
		end
	endfunction

	// wait until every expected result is out and the pipeline has emptied
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
		settle_block();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (sel)
			REG_WIDTH: begin
				cfg_width = int'(value);
			end
			REG_HEIGHT: begin
				cfg_height = int'(value);
			end
			REG_POLARITY: begin
				dark_bg = value[0];
			end
			default: begin
			end
		endcase
		restart_frame();
		// any write starts a fresh frame
		mid_frame = 1'b0;
		reg_writes++;
	endtask

	// one input transfer, with an optional idle burst ahead of it
	task automatic put_item(input bit cmd, input logic [PIX_W-1:0] pix, input bit typed,
		input bit t_has, input boundary_hit_t t_hit);
		int gap;
		bit got;
		boundary_hit_t hit;
		gap = 0;
		if ($urandom_range(0, 99) < src_gap_pct)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_boundary(cmd, pix, got, hit);
		if (typed) begin
			if (t_has)
				pending_hits.push_back(t_hit);
		end else if (got) begin
			pending_hits.push_back(hit);
		end
		item_count++;
	endtask

	// one frame plus its drain ticks, with stray items mixed in; may stop early
	task automatic stream_frame(input int abort_at, input int bg_pct);
		int w;
		int h;
		logic [PIX_W-1:0] pix;
		w = clamp_dim(cfg_width, MAX_WIDTH);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		mid_frame = 1'b1;
		for (int k = 0; k < w * h; k++) begin
			if (k == abort_at)
				return;
			if ($urandom_range(0, 29) == 0)
				put_item(CMD_DRAIN, PIX_W'($urandom()), 1'b0, 1'b0, '0);
			if ($urandom_range(0, 99) < bg_pct)
				pix = dark_bg ? BG_DARK : BG_LIGHT;
			else
				pix = PIX_W'($urandom_range(0, 255));
			put_item(CMD_PIXEL, pix, 1'b0, 1'b0, '0);
		end
		for (int k = 0; k < w; k++) begin
			if ($urandom_range(0, 19) == 0)
				put_item(CMD_PIXEL, PIX_W'($urandom()), 1'b0, 1'b0, '0);
			put_item(CMD_DRAIN, PIX_W'($urandom()), 1'b0, 1'b0, '0);
		end
		mid_frame = 1'b0;
	endtask

	// result side: random stalls and the in-order comparison
	always @(posedge clk) begin : result_check
		boundary_hit_t want;
		boundary_hit_t seen;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			// tdata holds col, row, seq_index from the lowest bit up
			seen = {m_axis_tdata[COL_FIELD_W-1:0],
			        m_axis_tdata[COL_FIELD_W +: ROW_FIELD_W],
			        m_axis_tdata[COL_FIELD_W + ROW_FIELD_W +: SEQ_W]};
			hit_count++;
			if (pending_hits.size() == 0) begin
				$error("unexpected result: col %0d row %0d seq_index %0d",
					seen.col, seen.row, seen.seq);
				error_count++;
			end else begin
				want = pending_hits.pop_front();
				if (seen.col !== want.col) begin
					$error("col: expected %0d, actual %0d", want.col, seen.col);
					error_count++;
				end
				if (seen.row !== want.row) begin
					$error("row: expected %0d, actual %0d", want.row, seen.row);
					error_count++;
				end
				if (seen.seq !== want.seq) begin
					$error("seq_index: expected %0d, actual %0d", want.seq, seen.seq);
					error_count++;
				end
			end
		end
		if (stall_left > 0 && snk_stall_pct != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < snk_stall_pct) begin
			stall_left = $urandom_range(1, 15) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// main sequence
	initial begin
		int base;
		int w;
		int h;
		bit pol;
		bit wrote;
		int bg_pct;
		int abort_at;
		int n_frames;
		src_gap_pct   = 20;
		snk_stall_pct = 20;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg)
				write_reg(directed_rows[i].sel, directed_rows[i].value);
			else
				put_item(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].typed,
					directed_rows[i].has_res, directed_rows[i].res);
		end

		// oversized registers clamp to the full frame; first row and a bit more
		write_reg(REG_WIDTH, 11'd2047);
		write_reg(REG_HEIGHT, 11'd2047);
		write_reg(REG_POLARITY, CFG_W'($urandom_range(0, 1)));
		stream_frame(MAX_WIDTH + 40, 40);

		// random small frames, some cut short by a register write
		base = item_count;
		while (item_count - base < RANDOM_ITEMS) begin
			if (item_count - base > RANDOM_ITEMS - QUIET_TAIL) begin
				src_gap_pct   = 0;
				snk_stall_pct = 0;
			end else begin
				src_gap_pct   = 10 * $urandom_range(0, 3);
				snk_stall_pct = 10 * $urandom_range(0, 3);
			end
			w   = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
			h   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 8);
			pol = 1'($urandom_range(0, 1));
			wrote = 1'b0;
			if (w != cfg_width || $urandom_range(0, 3) == 0) begin
				write_reg(REG_WIDTH, CFG_W'(w));
				wrote = 1'b1;
			end
			if (h != cfg_height || $urandom_range(0, 3) == 0) begin
				write_reg(REG_HEIGHT, CFG_W'(h));
				wrote = 1'b1;
			end
			if (pol != dark_bg || $urandom_range(0, 3) == 0) begin
				write_reg(REG_POLARITY, CFG_W'(pol));
				wrote = 1'b1;
			end
			if (mid_frame && !wrote)
				write_reg(REG_WIDTH, CFG_W'(w));
			bg_pct   = ($urandom_range(0, 1) == 0) ? 12 : 45;
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames && !mid_frame; f++) begin
				abort_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
				stream_frame(abort_at, bg_pct);
			end
		end

		settle_block();
		repeat (8) @(posedge clk);
		$display("run covered %0d stream items and %0d register writes", item_count, reg_writes);
		$display("%0d boundary pixels compared, frames from 1x1 up to 1024 wide", hit_count);
		if (error_count == 0 && pending_hits.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
